@@ src/mos_pkg.sv @@
// Package for the mode-of-set finder: widths, limits and the command and
// status types shared by the controller and the datapath.
// No dependencies.
package mos_pkg;

  localparam int VALUE_BITS = 8;
  localparam int NUM_BINS   = 1 << VALUE_BITS;
  localparam int MAX_ITEMS  = 4096;
  localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_LIMIT = count_t'(MAX_ITEMS);

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // word accepted: latch it and start the bin read
    logic update;  // bump the bin and the running best
    logic emit;    // move the best into the output register, clear the set
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;      // latched word closes the set
    logic out_busy;  // output register holds a word that is not taken this cycle
  } status_t;

endpackage

@@ src/mos_if.sv @@
// Valid/ready channel interfaces for the input words and the result words.
// Depends on mos_pkg for the field widths.
interface mos_in_if;
  logic            valid;
  logic            ready;
  mos_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface mos_out_if;
  logic            valid;
  logic            ready;
  mos_pkg::value_t mode_value;
  mos_pkg::count_t mode_count;

  modport source (output valid, output mode_value, output mode_count, input ready);
  modport sink   (input valid, input mode_value, input mode_count, output ready);
endinterface

@@ src/mode_of_set_finder.sv @@
// Top level of the mode-of-set finder: joins the controller and the datapath
// to the channel interfaces. Depends on mos_pkg, mos_if, mos_ctrl, mos_dp.
//
//   channel  dir  word fields                                   handshake
//   in_ch    in   value[7:0] signed, last                       valid/ready
//   out_ch   out  mode_value[7:0] signed, mode_count[12:0]      valid/ready
//
// A word passes through accept (bin read issued), then update (bin write
// and best compare); the registered histogram memory read sets this order.
// A word that closes a set adds an emit step, held with in_ready low while
// the output register is busy; a new word is accepted while a result waits.
// Reset (rst_n, synchronous, active low) clears all bin valid bits and the
// best at once; no clearing pass. The same happens after every emit.
module mode_of_set_finder (
  input  logic             clk,
  input  logic             rst_n,
  mos_in_if.sink           in_ch,
  mos_out_if.source        out_ch
);

  mos_pkg::cmd_t    cmd;
  mos_pkg::status_t status;

  // sequence the words: accept, update, emit
  mos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // histogram, running best and output register
  mos_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_value       (in_ch.value),
    .in_last        (in_ch.last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_mode_value (out_ch.mode_value),
    .out_mode_count (out_ch.mode_count)
  );

endmodule

@@ src/mos_ctrl.sv @@
// Controller for the mode-of-set finder: sequences accept, update and emit.
// Depends on mos_pkg (cmd_t, status_t).
module mos_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mos_pkg::status_t status,
  output mos_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_UPD  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = status.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // hold until the output register frees up
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_emit_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> $past(cmd.update) || $past(state_r == ST_EMIT))
    else $error("emit without a preceding update");
  a_update_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.update)
    else $error("accepted word not updated next cycle");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.update, cmd.emit}))
    else $error("more than one command at once");
`endif

endmodule

@@ src/mos_dp.sv @@
// Datapath for the mode-of-set finder: histogram memory, per-bin valid bits,
// running best and the output register. Depends on mos_pkg.
module mos_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  mos_pkg::cmd_t    cmd,
  output mos_pkg::status_t status,
  input  mos_pkg::value_t  in_value,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output mos_pkg::value_t  out_mode_value,
  output mos_pkg::count_t  out_mode_count
);

  mos_pkg::count_t              mem [mos_pkg::NUM_BINS];
  mos_pkg::count_t              rd_cnt_r;
  logic [mos_pkg::NUM_BINS-1:0] bin_valid_r;
  mos_pkg::value_t              idx_r;
  logic                         last_r;
  mos_pkg::value_t              best_val_r;
  mos_pkg::count_t              best_cnt_r;
  logic                         out_valid_r;
  mos_pkg::value_t              out_val_r;
  mos_pkg::count_t              out_cnt_r;

  mos_pkg::count_t cnt_base;
  mos_pkg::count_t cnt_new;
  logic            better;

  // a bin not yet seen in this set reads as zero
  assign cnt_base = bin_valid_r[idx_r] ? rd_cnt_r : '0;
  assign cnt_new  = (cnt_base < mos_pkg::COUNT_LIMIT) ? cnt_base + 1'b1 : cnt_base;
  assign better   = (cnt_new > best_cnt_r) ||
                    ((cnt_new == best_cnt_r) && ($signed(idx_r) < $signed(best_val_r)));

  // histogram memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      mem[idx_r] <= cnt_new;
    end
    if (cmd.load) begin
      rd_cnt_r <= mem[in_value];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r  <= in_value;
      last_r <= in_last;
    end
    if (cmd.emit) begin
      out_val_r <= best_val_r;
      out_cnt_r <= best_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_valid_r <= '0;
      best_val_r  <= '0;
      best_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        bin_valid_r[idx_r] <= 1'b1;
        if (better) begin
          best_val_r <= idx_r;
          best_cnt_r <= cnt_new;
        end
      end
      if (cmd.emit) begin
        bin_valid_r <= '0;
        best_val_r  <= '0;
        best_cnt_r  <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.last     = last_r;
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid      = out_valid_r;
  assign out_mode_value = out_val_r;
  assign out_mode_count = out_cnt_r;

`ifndef SYNTHESIS
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    best_cnt_r <= mos_pkg::COUNT_LIMIT)
    else $error("best count beyond limit");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (best_cnt_r == '0) && (bin_valid_r == '0) && out_valid_r)
    else $error("set not cleared after emit");
  a_bin_marked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> bin_valid_r[$past(idx_r)] && (best_cnt_r != '0))
    else $error("bin or best not updated");
  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cnt_r != '0)
    else $error("result with zero count");
`endif

endmodule
